// ===== hw/rtl/indexed_list_insert_delete_assert.svh =====
// ----------------------------------------------------------------------------
// indexed list assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

`ifndef ASSERT_OFF
`define ILI_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define ILI_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define ILI_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg)
`define ILI_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/ili_pkg.sv =====
// ----------------------------------------------------------------------------
// ili_pkg
// beat types, operation codes and status codes of the indexed list
// ----------------------------------------------------------------------------
package ili_pkg;

  localparam int FUNC_W = 3;
  localparam int POS_W  = 11;
  localparam int VAL_W  = 16;
  localparam int RV_W   = 17;
  localparam int ST_W   = 2;
  localparam int LEN_W  = 11;

  localparam logic [FUNC_W-1:0] FN_GET      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_HEAD = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_TAIL = 3'd2;
  localparam logic [FUNC_W-1:0] FN_INS_POS  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL      = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  localparam logic signed [RV_W-1:0] RV_NONE = -17'sd1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic signed [RV_W-1:0] read_value;
    logic [ST_W-1:0]        status;
    logic [LEN_W-1:0]       length;
  } rsp_t;

  typedef struct packed {
    logic busy;
    logic fin;
  } ili_stat_t;

endpackage

// ===== hw/rtl/ili_ram.sv =====
// ----------------------------------------------------------------------------
// ili_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ili_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ili_ctrl.sv =====
// ----------------------------------------------------------------------------
// ili_ctrl
// list sequencer: decodes one command, walks the entry ram one entry per
// cycle through a shared address stepper, and holds the result
// ----------------------------------------------------------------------------
module ili_ctrl #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ili_pkg::cmd_t     cmd,
  input  logic              out_free,
  output ili_pkg::ili_stat_t stat,
  output ili_pkg::rsp_t     result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > ili_pkg::POS_W) ? LW : ili_pkg::POS_W;
  localparam int XW = (VALUE_BITS > ili_pkg::RV_W) ? VALUE_BITS : ili_pkg::RV_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_GETW,
    S_SHIFT,
    S_DRAIN,
    S_FILL,
    S_FIN
  } state_t;

  state_t state;

  logic [ili_pkg::FUNC_W-1:0] func;
  logic [CW-1:0]              pos;
  logic [VALUE_BITS-1:0]      val;
  logic [LW-1:0]              len;
  logic [AW-1:0]              idx;
  logic [AW-1:0]              last;
  logic [AW-1:0]              base;
  logic                       up;
  logic                       pend;
  logic [AW-1:0]              pend_addr;
  logic signed [ili_pkg::RV_W-1:0] rv;
  logic [ili_pkg::ST_W-1:0]   st;

  logic [CW-1:0]         nx;
  logic [CW-1:0]         ins_p;
  logic [XW-1:0]         valx;
  logic [XW-1:0]         rdx;
  logic [CW-1:0]         lenx;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [VALUE_BITS-1:0] rdata;

  assign nx   = CW'(len);
  assign lenx = CW'(len);
  assign valx = XW'(cmd.value);
  assign rdx  = XW'(rdata);

  always_comb begin
    case (func)
      ili_pkg::FN_INS_HEAD: ins_p = '0;
      ili_pkg::FN_INS_TAIL: ins_p = nx;
      default:              ins_p = pos;
    endcase
  end

  // shared ram port steering
  always_comb begin
    raddr = (state == S_DEC) ? pos[AW-1:0] : idx;
    if (state == S_FILL) begin
      we    = 1'b1;
      waddr = base;
      wdata = val;
    end else begin
      we    = pend;
      waddr = pend_addr;
      wdata = rdata;
    end
  end

  ili_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            func  <= cmd.func;
            pos   <= CW'(cmd.position);
            val   <= valx[VALUE_BITS-1:0];
            rv    <= ili_pkg::RV_NONE;
            st    <= ili_pkg::ST_DONE;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          case (func)
            ili_pkg::FN_GET: begin
              if (pos < nx) begin
                state <= S_GETW;
              end else begin
                st    <= ili_pkg::ST_INVALID;
                state <= S_FIN;
              end
            end
            ili_pkg::FN_INS_HEAD, ili_pkg::FN_INS_TAIL, ili_pkg::FN_INS_POS: begin
              if (func == ili_pkg::FN_INS_POS && pos > nx) begin
                st    <= ili_pkg::ST_INVALID;
                state <= S_FIN;
              end else if (nx == CW'(CAPACITY)) begin
                st    <= ili_pkg::ST_FULL;
                state <= S_FIN;
              end else begin
                base <= ins_p[AW-1:0];
                if (ins_p == nx) begin
                  state <= S_FILL;
                end else begin
                  idx   <= AW'(nx - CW'(1));
                  last  <= ins_p[AW-1:0];
                  up    <= 1'b0;
                  state <= S_SHIFT;
                end
              end
            end
            ili_pkg::FN_DEL: begin
              if (pos < nx) begin
                if (pos + CW'(1) == nx) begin
                  len   <= len - LW'(1);
                  state <= S_FIN;
                end else begin
                  idx   <= AW'(pos + CW'(1));
                  last  <= AW'(nx - CW'(1));
                  up    <= 1'b1;
                  state <= S_SHIFT;
                end
              end else begin
                st    <= ili_pkg::ST_INVALID;
                state <= S_FIN;
              end
            end
            default: begin
              st    <= ili_pkg::ST_INVALID;
              state <= S_FIN;
            end
          endcase
        end
        S_GETW: begin
          rv    <= $signed(rdx[ili_pkg::RV_W-1:0]);
          state <= S_FIN;
        end
        S_SHIFT: begin
          // read one entry, write the previous one a slot over
          pend      <= 1'b1;
          pend_addr <= up ? idx - AW'(1) : idx + AW'(1);
          if (idx == last) begin
            state <= S_DRAIN;
          end else begin
            idx <= up ? idx + AW'(1) : idx - AW'(1);
          end
        end
        S_DRAIN: begin
          pend <= 1'b0;
          if (up) begin
            len   <= len - LW'(1);
            state <= S_FIN;
          end else begin
            state <= S_FILL;
          end
        end
        S_FILL: begin
          len   <= len + LW'(1);
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.fin  = (state == S_FIN) && out_free;

  assign result.read_value = rv;
  assign result.status     = st;
  assign result.length     = lenx[ili_pkg::LEN_W-1:0];

endmodule

// ===== hw/rtl/indexed_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// ordered list of up to CAPACITY values with get, insert and delete by position
// ----------------------------------------------------------------------------
// usage:
//   the cmd channel carries one operation per beat (func, position, value);
//   the rsp channel returns exactly one beat per command with the value read,
//   a status and the list length after the operation.
//   one command is worked on at a time; cmd_stall stays high from the beat
//   after acceptance until the result has moved into the rsp register.
//   a get goes through decode, the ram read and finish; an insert at the
//   end through decode, fill and finish; rejected commands and delete of the
//   last entry from decode to finish; other inserts through decode, shift,
//   drain, fill and finish, other deletes through decode, shift, drain and
//   finish. shift moves the entries behind the position one per cycle through
//   the single read and write port of the entry ram (up to CAPACITY - 1 moves).
//   a new command is taken once the sequencer is back in idle, as rsp_valid rises.
//   the rsp register holds a finished result while rsp_stall is high; the
//   next command may already be accepted and worked on, and its result
//   waits in the sequencer until the register frees.
//   reset empties the list at once; the entry ram needs no clearing pass.
// ----------------------------------------------------------------------------
`include "indexed_list_insert_delete_assert.svh"

module indexed_list_insert_delete #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  ili_pkg::cmd_t  cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ili_pkg::rsp_t  rsp
);

  ili_pkg::ili_stat_t stat;
  ili_pkg::rsp_t      result;
  logic               start;
  logic               out_free;

  assign cmd_stall = stat.busy;
  assign start     = cmd_valid && !cmd_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  ili_ctrl #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .out_free(out_free),
    .stat    (stat),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stat.fin) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.fin) begin
      rsp <= result;
    end
  end

  `ILI_ASSERT_NEXT(a_busy_after_accept, clk, rst, start, cmd_stall, "not busy after accept")
  `ILI_ASSERT_IMPLY(a_len_bound, clk, rst, rsp_valid, rsp.length <= CAPACITY, "length over capacity")
  `ILI_ASSERT_IMPLY(a_full_len, clk, rst, rsp_valid && rsp.status == ili_pkg::ST_FULL, rsp.length == CAPACITY, "full flagged below capacity")
  `ILI_ASSERT_IMPLY(a_read_done, clk, rst, rsp_valid && rsp.read_value != ili_pkg::RV_NONE, rsp.status == ili_pkg::ST_DONE, "value read on failed command")

endmodule
